[rtl/ksd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_pkg: shared constants for the koch segment subdivider
// widths of the datapath, register indexes and configuration reset values
// ----------------------------------------------------------------------------
package ksd_pkg;

  // coordinate and datapath widths
  localparam int PT_W   = 32;              // q16.16 coordinate
  localparam int DIFF_W = PT_W + 1;        // exact coordinate difference
  localparam int COEF_W = 17;              // q0.16 zero-extended or q1.14 sign-extended
  localparam int PROD_W = DIFF_W + COEF_W; // full product
  localparam int ACC_W  = PROD_W + 1;      // sum of two products
  localparam int SUM_W  = ACC_W + 1;       // base plus shifted term

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SIDES_W    = 6;
  localparam int FAC_W      = 16;
  localparam int ROT_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDES  = 2'd0,
    REG_FACTOR = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } reg_idx_e;

  // reset values of the configuration registers
  localparam logic [SIDES_W-1:0] SIDES_RST  = 6'd3;
  localparam logic [FAC_W-1:0]   FACTOR_RST = 16'd21845;
  localparam logic [ROT_W-1:0]   COS_RST    = 16'd8192;
  localparam logic [ROT_W-1:0]   SIN_RST    = 16'hC893;  // -14189

  // shift applied to the product sum
  localparam int SPLIT_SHIFT = 16;
  localparam int ROT_SHIFT   = 14;

  localparam int MAX_SIDES_DEF = 32;

  // clamp to the signed 32-bit range
  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(PT_W-1){1'b1}}}));
    lo = SUM_W'(signed'({1'b1, {(PT_W-1){1'b0}}}));
    if (v > hi) begin
      sat_pt = hi[PT_W-1:0];
    end else if (v < lo) begin
      sat_pt = lo[PT_W-1:0];
    end else begin
      sat_pt = v[PT_W-1:0];
    end
  endfunction

endpackage

[rtl/koch_segment_subdivider.sv]
`timescale 1ns / 1ps
// the first point is offered once its segment is accepted and its step leaves write
// each point has its own step, and a step stalls in write while the output is full;
//   one extra step computes the far split point, which is not emitted
// steps are paced by the single shared 33x17 multiplier, four products per point
// a new segment is taken while the last point still waits in the output register
// reset: configuration returns to its defaults, sequencer idle, no point pending
// ----------------------------------------------------------------------------
// koch_segment_subdivider: iterative koch bump generator
// for each segment A->B emits the n interior points of a bump, computed by
// one shared multiply-accumulate unit under a small one-hot sequencer
// ----------------------------------------------------------------------------
module koch_segment_subdivider
  import ksd_pkg::*;
#(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // segment words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [4*PT_W-1:0]     s_axis_tdata,   // start_x, start_y, end_x, end_y
  // point words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*PT_W-1:0]     m_axis_tdata,   // point_x, point_y
  output logic                  m_axis_tlast    // last point of the segment
);

  // step counter holds 0 .. MAX_SIDES
  localparam int NW   = $clog2(MAX_SIDES + 1);
  localparam int CMPW = (NW > SIDES_W) ? NW : SIDES_W;

  // one step = diff, four multiplies, one accumulate, final add, write
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_M0   = 9'b000000100,
    S_M1   = 9'b000001000,
    S_M2   = 9'b000010000,
    S_M3   = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_WR   = 9'b100000000
  } st_e;

  st_e st_q, st_d;

  // configuration registers
  logic [SIDES_W-1:0]      sides_q;
  logic [FAC_W-1:0]        fac_q;
  logic signed [ROT_W-1:0] cos_q;
  logic signed [ROT_W-1:0] sin_q;

  // segment endpoints
  logic signed [PT_W-1:0] ax_q, ay_q, bx_q, by_q;
  // chain points: cur is q(k), prev is q(k-1)
  logic signed [PT_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  // new point under construction
  logic signed [PT_W-1:0] new_x_q, new_y_q;
  // operands of the current step
  logic signed [PT_W-1:0]   base_x_q, base_y_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  // mac unit
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [NW-1:0] step_q;
  logic [NW-1:0] n_q;

  // output register
  logic                   out_valid_q;
  logic signed [PT_W-1:0] out_x_q, out_y_q;
  logic                   out_last_q;

  logic in_acc;
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // clamp sides into 2 .. MAX_SIDES
  logic [CMPW-1:0] sides_ext, n_clamp;
  assign sides_ext = CMPW'(sides_q);
  assign n_clamp   = (sides_ext < CMPW'(2)) ? CMPW'(2) :
                     (sides_ext > CMPW'(MAX_SIDES)) ? CMPW'(MAX_SIDES) : sides_ext;

  // the first two steps are the split points, the rest rotations
  logic split_step, far_step, last_step;
  assign split_step = (step_q < NW'(2));
  assign far_step   = (step_q == NW'(1));
  assign last_step  = (step_q == n_q);

  // coefficients: split uses (factor, 0), rotation uses (cos, sin)
  logic signed [COEF_W-1:0] coef_c, coef_s;
  assign coef_c = split_step ? signed'({1'b0, fac_q}) : COEF_W'(cos_q);
  assign coef_s = split_step ? '0 : COEF_W'(sin_q);

  // shared multiplier operand selection
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  always_comb begin
    mul_a = dx_q;
    mul_b = coef_c;
    case (st_q)
      S_M0: begin mul_a = dx_q; mul_b = coef_c; end  // c*dx
      S_M1: begin mul_a = dy_q; mul_b = coef_s; end  // s*dy
      S_M2: begin mul_a = dx_q; mul_b = coef_s; end  // s*dx
      S_M3: begin mul_a = dy_q; mul_b = coef_c; end  // c*dy
      default: begin mul_a = dx_q; mul_b = coef_c; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // final add: base plus floor-shifted sum, saturated
  logic signed [ACC_W-1:0]  term;
  logic signed [PT_W-1:0]   fin_base;
  logic signed [SUM_W-1:0]  fin_sum;
  logic signed [PT_W-1:0]   fin_pt;
  assign term     = split_step ? (acc_q >>> SPLIT_SHIFT) : (acc_q >>> ROT_SHIFT);
  assign fin_base = (st_q == S_FIN) ? base_y_q : base_x_q;
  assign fin_sum  = SUM_W'(fin_base) + SUM_W'(term);
  assign fin_pt   = sat_pt(fin_sum);

  // step operands: q1 from A toward B, far point from B toward A, then chain
  logic signed [PT_W-1:0] op_bx, op_by, op_fx, op_fy;
  always_comb begin
    if (step_q == '0) begin
      op_bx = ax_q; op_by = ay_q; op_fx = bx_q; op_fy = by_q;
    end else if (far_step) begin
      op_bx = bx_q; op_by = by_q; op_fx = ax_q; op_fy = ay_q;
    end else begin
      op_bx = cur_x_q; op_by = cur_y_q; op_fx = prev_x_q; op_fy = prev_y_q;
    end
  end

  // write stage waits for the output slot, the far point needs none
  logic emit, wr_go, out_load;
  assign emit     = !far_step;
  assign wr_go    = !emit || !out_valid_q || m_axis_tready;
  assign out_load = (st_q == S_WR) && emit && wr_go;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_acc) st_d = S_DIFF;
      S_DIFF: st_d = S_M0;
      S_M0:   st_d = S_M1;
      S_M1:   st_d = S_M2;
      S_M2:   st_d = S_M3;
      S_M3:   st_d = S_ACC;
      S_ACC:  st_d = S_FIN;
      S_FIN:  st_d = S_WR;
      S_WR: begin
        if (wr_go) st_d = last_step ? S_IDLE : S_DIFF;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      step_q      <= '0;
      n_q         <= NW'(2);
      out_valid_q <= 1'b0;
      sides_q     <= SIDES_RST;
      fac_q       <= FACTOR_RST;
      cos_q       <= COS_RST;
      sin_q       <= SIN_RST;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        step_q <= '0;
        n_q    <= n_clamp[NW-1:0];
      end else if (st_q == S_WR && wr_go && !last_step) begin
        step_q <= step_q + NW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SIDES:  sides_q <= cfg_data_i[SIDES_W-1:0];
          REG_FACTOR: fac_q   <= cfg_data_i[FAC_W-1:0];
          REG_COS:    cos_q   <= cfg_data_i[ROT_W-1:0];
          REG_SIN:    sin_q   <= cfg_data_i[ROT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= s_axis_tdata[0*PT_W +: PT_W];
      ay_q <= s_axis_tdata[1*PT_W +: PT_W];
      bx_q <= s_axis_tdata[2*PT_W +: PT_W];
      by_q <= s_axis_tdata[3*PT_W +: PT_W];
    end
    case (st_q)
      S_DIFF: begin
        base_x_q <= op_bx;
        base_y_q <= op_by;
        dx_q     <= DIFF_W'(op_fx) - DIFF_W'(op_bx);
        dy_q     <= DIFF_W'(op_fy) - DIFF_W'(op_by);
      end
      S_M0: prod_q <= prod;
      S_M1: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= prod;
      end
      S_M2: begin
        acc_q  <= acc_q - ACC_W'(prod_q);   // c*dx - s*dy
        prod_q <= prod;
      end
      S_M3: begin
        new_x_q <= fin_pt;
        acc_q   <= ACC_W'(prod_q);
        prod_q  <= prod;
      end
      S_ACC: acc_q <= acc_q + ACC_W'(prod_q);  // s*dx + c*dy
      S_FIN: new_y_q <= fin_pt;
      S_WR: begin
        if (wr_go) begin
          if (step_q == '0) begin
            cur_x_q <= new_x_q;
            cur_y_q <= new_y_q;
          end else if (far_step) begin
            prev_x_q <= new_x_q;
            prev_y_q <= new_y_q;
          end else begin
            prev_x_q <= cur_x_q;
            prev_y_q <= cur_y_q;
            cur_x_q  <= new_x_q;
            cur_y_q  <= new_y_q;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_q    <= new_x_q;
      out_y_q    <= new_y_q;
      out_last_q <= last_step;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

  // step counter never passes the side count of the running segment
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> (step_q <= n_q))
    else $error("step counter beyond side count");

  // latched side count stays in the clamped range
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q >= NW'(2)) && (n_q <= NW'(MAX_SIDES)))
    else $error("side count out of range");

  // an accepted segment starts at step zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == S_DIFF) && (step_q == '0))
    else $error("segment did not start at first step");

  // writing the last point returns to idle with a point pending
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WR && wr_go && last_step) |=> (st_q == S_IDLE) && out_valid_q && m_axis_tlast)
    else $error("last point did not end the segment");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: koch segment subdivider
// sends segment words and register writes, predicts every bump point in
// fixed point and checks each point word field by field, with random
// back-pressure on both streams, one long output stall and a quiet tail
// ----------------------------------------------------------------------------
module testbench;
  import ksd_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     BUMP_MAX     = MAX_SIDES_DEF;
  localparam int     SETTLE_CYC   = 24;          // settle time, in cycles
  localparam int     LONG_HOLD    = 300;         // long receiver stall, in cycles
  localparam longint RUN_LIMIT_NS = 6_000_000;
  localparam longint PT_MAX       = 64'sd2147483647;
  localparam longint PT_MIN       = -64'sd2147483648;
  localparam real    PI           = 3.14159265358979;

  // one expected point word
  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   last;
  } bump_point_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [4*PT_W-1:0]     s_axis_tdata  = '0;   // start_x, start_y, end_x, end_y
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*PT_W-1:0]     m_axis_tdata;         // point_x, point_y
  logic                  m_axis_tlast;

  // shadow of the configuration registers
  logic [SIDES_W-1:0] sides_r        = SIDES_RST;
  logic [FAC_W-1:0]   split_factor_r = FACTOR_RST;
  logic [ROT_W-1:0]   rot_cos_r      = COS_RST;
  logic [ROT_W-1:0]   rot_sin_r      = SIN_RST;

  bump_point_t bump_points_q[$];   // points still owed by the block

  bit idle_on        = 1'b1;       // random bursts of idling on both sides
  int rx_hold_cycles = 0;          // request for a long receiver stall
  int seg_sent       = 0;
  int pts_checked    = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;

  always #CLK_HALF clk_i = ~clk_i;

  koch_segment_subdivider i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // point predictor
  // --------------------------------------------------------------------------

  function automatic longint clamp_pt(input longint v);
    if (v > PT_MAX) begin
      return PT_MAX;
    end else if (v < PT_MIN) begin
      return PT_MIN;
    end
    return v;
  endfunction

  // q = base + R(from - base); sums are exact, >>> floors toward minus infinity
  function automatic void rotate_about(input longint bx, input longint by,
                                       input longint fx, input longint fy,
                                       output longint qx, output longint qy);
    longint c;
    longint s;
    longint dx;
    longint dy;
    c  = longint'($signed(rot_cos_r));
    s  = longint'($signed(rot_sin_r));
    dx = fx - bx;
    dy = fy - by;
    qx = clamp_pt(bx + ((c * dx - s * dy) >>> ROT_SHIFT));
    qy = clamp_pt(by + ((s * dx + c * dy) >>> ROT_SHIFT));
  endfunction

  // queue the n points of the bump raised on one segment word
  function automatic void predict_bump(input logic [4*PT_W-1:0] seg);
    longint      px [BUMP_MAX];
    longint      py [BUMP_MAX];
    longint      ax;
    longint      ay;
    longint      bx;
    longint      by;
    longint      f;
    int          n;
    int          k;
    bump_point_t pt;
    ax = longint'($signed(seg[0*PT_W +: PT_W]));
    ay = longint'($signed(seg[1*PT_W +: PT_W]));
    bx = longint'($signed(seg[2*PT_W +: PT_W]));
    by = longint'($signed(seg[3*PT_W +: PT_W]));
    f  = longint'({1'b0, split_factor_r});
    // side count codes below two or above the maximum are clamped
    n = int'(sides_r);
    if (n < 2) n = 2;
    if (n > BUMP_MAX) n = BUMP_MAX;
    px[0]   = clamp_pt(ax + (((bx - ax) * f) >>> SPLIT_SHIFT));
    py[0]   = clamp_pt(ay + (((by - ay) * f) >>> SPLIT_SHIFT));
    px[n-1] = clamp_pt(bx + (((ax - bx) * f) >>> SPLIT_SHIFT));
    py[n-1] = clamp_pt(by + (((ay - by) * f) >>> SPLIT_SHIFT));
    // with two sides this overwrites the far split point, no chain follows
    rotate_about(px[0], py[0], px[n-1], py[n-1], px[1], py[1]);
    for (k = 1; k + 1 < n; k++) begin
      rotate_about(px[k], py[k], px[k-1], py[k-1], px[k+1], py[k+1]);
    end
    for (k = 0; k < n; k++) begin
      pt.x    = px[k][PT_W-1:0];
      pt.y    = py[k][PT_W-1:0];
      pt.last = (k == n - 1);
      bump_points_q.push_back(pt);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [PT_W-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = int'(PT_MIN);
          1:       v = int'(PT_MAX);
          2:       v = 0;
          default: v = -1;
        endcase
      end
      // plotting range, about +-200.0
      default: v = int'($urandom_range(0, 26214400)) - 13107200;
    endcase
    return v;
  endfunction

  // cosine and sine of pi + 2pi/n in q1.14, as the host would load them
  function automatic void koch_rotation(input int n, output logic [ROT_W-1:0] c,
                                        output logic [ROT_W-1:0] s);
    real th;
    th = PI + 2.0 * PI / n;
    c  = ROT_W'(int'($cos(th) * 16384.0));
    s  = ROT_W'(int'($sin(th) * 16384.0));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // one register write; valid is lowered again before the task returns
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_SIDES:  sides_r        = val[SIDES_W-1:0];
      REG_FACTOR: split_factor_r = val;
      REG_COS:    rot_cos_r      = val;
      REG_SIN:    rot_sin_r      = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_bump(input logic [CFG_DATA_W-1:0] sides_word,
                          input logic [FAC_W-1:0] factor,
                          input logic [ROT_W-1:0] c, input logic [ROT_W-1:0] s);
    write_reg(REG_SIDES, sides_word);
    write_reg(REG_FACTOR, factor);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
  endtask

  // offer one segment word; tvalid is left high so the next word is offered
  // with no drop in valid; random gaps and wait_drained lower it
  task automatic send_segment(input logic signed [PT_W-1:0] ax, input logic signed [PT_W-1:0] ay,
                              input logic signed [PT_W-1:0] bx, input logic signed [PT_W-1:0] by);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {by, bx, ay, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_bump({by, bx, ay, ax});
    seg_sent++;
  endtask

  task automatic send_random_segment();
    send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // stop offering, wait for every owed point, then let the sequencer settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bump_points_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus the long stall counted here
  // --------------------------------------------------------------------------
  initial begin : point_sink
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // checker: every accepted point word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : point_check
    bump_point_t            want;
    logic signed [PT_W-1:0] got_x;
    logic signed [PT_W-1:0] got_y;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[0 +: PT_W];
      got_y = m_axis_tdata[PT_W +: PT_W];
      if (bump_points_q.size() == 0) begin
        note_mismatch($sformatf("unexpected point x=%0d y=%0d last=%0b",
                                got_x, got_y, m_axis_tlast));
      end else begin
        want = bump_points_q.pop_front();
        if (got_x !== want.x) begin
          note_mismatch($sformatf("point %0d x: expected %0d, got %0d",
                                  pts_checked, want.x, got_x));
        end
        if (got_y !== want.y) begin
          note_mismatch($sformatf("point %0d y: expected %0d, got %0d",
                                  pts_checked, want.y, got_y));
        end
        if (m_axis_tlast !== want.last) begin
          note_mismatch($sformatf("point %0d last: expected %0b, got %0b",
                                  pts_checked, want.last, m_axis_tlast));
        end
      end
      pts_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset configuration: three sides, one third split, classic koch rotation
  task automatic test_reset_defaults();
    send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_segment(32'sd0, 32'sd0, 32'sd196608, 32'sd0);
    send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_segment(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_segment(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_segment(-32'sd1, -32'sd1, 32'sd1, 32'sd1);
    wait_drained();
  endtask

  // side count clamping, split and rotation extremes, one segment each
  task automatic test_config_extremes();
    logic [ROT_W-1:0] c;
    logic [ROT_W-1:0] s;
    // code zero with the upper data bits set, treated as two sides
    set_bump(16'hFFC0, FACTOR_RST, COS_RST, SIN_RST);
    send_segment(32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF, 32'sd65536);
    wait_drained();
    set_bump(16'h0001, FACTOR_RST, COS_RST, SIN_RST);
    send_segment(32'sd0, 32'sd0, 32'sd6553600, 32'sd0);
    wait_drained();
    koch_rotation(2, c, s);
    set_bump(16'h0002, FACTOR_RST, c, s);
    send_segment(-32'sd655360, 32'sd327680, 32'sd655360, -32'sd327680);
    wait_drained();
    koch_rotation(BUMP_MAX, c, s);
    set_bump(16'h0020, FACTOR_RST, c, s);
    send_segment(32'sd0, 32'sd0, 32'sd13107200, 32'sd0);
    wait_drained();
    // code above the maximum, clamped to the maximum
    set_bump(16'h003F, 16'd4096, c, s);
    send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    wait_drained();
    koch_rotation(4, c, s);
    set_bump(16'h0004, 16'd0, c, s);
    send_segment(32'sd65536, -32'sd65536, 32'sd9830400, 32'sd1234567);
    wait_drained();
    set_bump(16'h0004, 16'hFFFF, c, s);
    send_segment(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    wait_drained();
    // unit rotation puts each new point on the point it is rotated from
    set_bump(16'h0003, FACTOR_RST, 16'h4000, 16'h0000);
    send_segment(32'sd0, 32'sd0, 32'sd3276800, 32'sd3276800);
    wait_drained();
    set_bump(16'h0003, FACTOR_RST, 16'hC000, 16'h4000);
    send_segment(32'sd1000000, -32'sd2000000, -32'sd3000000, 32'sd4000000);
    wait_drained();
    // rotation codes far beyond one grow each step until they saturate
    set_bump(16'h0005, 16'h8000, 16'h8000, 16'h7FFF);
    send_segment(32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    wait_drained();
  endtask

  // phases of random segments, each under a fresh random configuration
  task automatic test_random_segments(input int target);
    int               base;
    int               n_raw;
    int               n_eff;
    logic [FAC_W-1:0] fac;
    logic [ROT_W-1:0] c;
    logic [ROT_W-1:0] s;
    base = seg_sent;
    while (seg_sent - base < target) begin
      // mostly small bumps, now and then any code up to the widest
      n_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 6);
      n_eff = (n_raw < 2) ? 2 : (n_raw > BUMP_MAX) ? BUMP_MAX : n_raw;
      fac   = ($urandom_range(0, 2) == 0) ? FACTOR_RST : FAC_W'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        c = ROT_W'($urandom);
        s = ROT_W'($urandom);
      end else begin
        koch_rotation(n_eff, c, s);
      end
      set_bump({10'($urandom), 6'(n_raw)}, fac, c, s);
      repeat ($urandom_range(6, 14)) send_random_segment();
      wait_drained();
    end
  endtask

  // receiver stalls long while segments keep coming, so the input backs up
  task automatic test_backpressure();
    logic [ROT_W-1:0] c;
    logic [ROT_W-1:0] s;
    koch_rotation(4, c, s);
    set_bump(16'h0004, FACTOR_RST, c, s);
    rx_hold_cycles = LONG_HOLD;
    repeat (8) send_random_segment();
    wait_drained();
  endtask

  // closing stretch with both sides running flat out
  task automatic test_steady_stream();
    logic [ROT_W-1:0] c;
    logic [ROT_W-1:0] s;
    idle_on = 1'b0;
    koch_rotation(3, c, s);
    set_bump(16'h0003, FACTOR_RST, c, s);
    repeat (8) send_random_segment();
    wait_drained();
    set_bump(16'h0002, FAC_W'($urandom), ROT_W'($urandom), ROT_W'($urandom));
    repeat (6) send_random_segment();
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_random_segments(80);
    test_backpressure();
    test_steady_stream();
    $display("checked %0d points from %0d segments across %0d register writes",
             pts_checked, seg_sent, cfg_writes);
    $display("side codes 0..63, split and rotation extremes, long stall, steady tail");
    if (mismatches == 0 && bump_points_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("timeout with %0d points still owed", bump_points_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
